[src/ptt_pkg.sv]
// Shared types and constants for the periodic timer table.
package ptt_pkg;

  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned PERIOD_BITS_DEF = 32;

  localparam logic [1:0] KIND_ADD        = 2'd0;
  localparam logic [1:0] KIND_REMOVE     = 2'd1;
  localparam logic [1:0] KIND_SET_PERIOD = 2'd2;
  localparam logic [1:0] KIND_TICK       = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;
  localparam logic [1:0] ST_FIRED    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] period;
    logic [47:0] now;
  } ptt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_out;
    logic       last;
  } ptt_out_t;

endpackage

[src/ptt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ptt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/periodic_timer_table.sv]
// Periodic timer table: slot allocation, removal, period update and tick scan.
//
// Input channel (in_valid / in_stall / in_data) takes one command item at a
// time: add, remove, set period or tick. Result channel (out_valid /
// out_stall / out_data) returns the results of that item in order; the
// final result of each item carries last = 1.
// Remove and set period pass through the edit state before their result is
// registered. Add walks the in-use bits from slot 0 to the first free one,
// and reports full if none is free. A tick streams the interval and deadline
// memories one slot per cycle while no fired slot waits on a result stall,
// reading the next slot while the current one is compared and written back.
// A new item is taken once the last result of the previous one is in the
// output register, so items never overlap in the table. A stall on the
// result channel holds the output register and the scan on the slot that
// waits to report; the input channel stalls meanwhile.
// Reset clears all in-use bits and the control state; the memories keep
// their contents and are written by add before any read that matters.
module periodic_timer_table import ptt_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ptt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ptt_out_t out_data
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_EDIT,
    S_SCAN,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [SLOTS-1:0]       in_use_r, in_use_nxt;
  logic                   out_vld_r, out_vld_nxt;
  ptt_out_t               out_item_r;

  logic [1:0]             kind_r;
  logic [3:0]             slot_r;
  logic [PERIOD_BITS-1:0] period_r;
  logic [TIME_BITS-1:0]   now_r;

  logic                   in_accept;
  logic                   out_ok;
  logic                   emit;
  ptt_out_t               emit_item;
  logic [SLOT_W-1:0]      slot_idx;
  logic                   slot_ok;
  logic                   fire;

  logic                   iv_we;
  logic [SLOT_W-1:0]      iv_waddr;
  logic [PERIOD_BITS-1:0] iv_wdata;
  logic [PERIOD_BITS-1:0] iv_rdata;
  logic                   dl_we;
  logic [SLOT_W-1:0]      dl_waddr;
  logic [TIME_BITS-1:0]   dl_wdata;
  logic [TIME_BITS-1:0]   dl_rdata;

  ptt_ram #(
    .WIDTH (PERIOD_BITS),
    .DEPTH (SLOTS)
  ) u_interval_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (iv_waddr),
    .wdata (iv_wdata),
    .raddr (idx_nxt),
    .rdata (iv_rdata)
  );

  ptt_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (SLOTS)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (idx_nxt),
    .rdata (dl_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_ok    = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  assign slot_idx = SLOT_W'(slot_r);
  assign slot_ok  = (32'(slot_r) < 32'(SLOTS));
  assign fire     = in_use_r[idx_r] && (now_r > dl_rdata);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    in_use_nxt = in_use_r;
    emit       = 1'b0;
    emit_item  = '0;
    iv_we      = 1'b0;
    iv_waddr   = idx_r;
    iv_wdata   = period_r;
    dl_we      = 1'b0;
    dl_waddr   = idx_r;
    dl_wdata   = now_r;

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_accept) begin
          unique case (in_data.kind)
            KIND_ADD:        state_nxt = S_ADD;
            KIND_REMOVE:     state_nxt = S_EDIT;
            KIND_SET_PERIOD: state_nxt = S_EDIT;
            KIND_TICK:       state_nxt = S_SCAN;
            default:         state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        priority if (!in_use_r[idx_r]) begin
          if (out_ok) begin
            in_use_nxt[idx_r]  = 1'b1;
            iv_we              = 1'b1;
            dl_we              = 1'b1;
            emit               = 1'b1;
            emit_item.status   = ST_DONE;
            emit_item.slot_out = 4'(idx_r);
            emit_item.last     = 1'b1;
            idx_nxt            = '0;
            state_nxt          = S_IDLE;
          end
        end else if (idx_r == LAST_IDX) begin
          if (out_ok) begin
            emit             = 1'b1;
            emit_item.status = ST_FULL;
            emit_item.last   = 1'b1;
            idx_nxt          = '0;
            state_nxt        = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      S_EDIT: begin
        if (out_ok) begin
          emit               = 1'b1;
          emit_item.slot_out = slot_r;
          emit_item.last     = 1'b1;
          if (slot_ok && in_use_r[slot_idx]) begin
            emit_item.status = ST_DONE;
            if (kind_r == KIND_REMOVE) begin
              in_use_nxt[slot_idx] = 1'b0;
            end else begin
              iv_we    = 1'b1;
              iv_waddr = slot_idx;
            end
          end else begin
            emit_item.status = ST_NOT_USED;
          end
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!fire || out_ok) begin
          if (fire) begin
            dl_we              = 1'b1;
            dl_wdata           = dl_rdata + TIME_BITS'(iv_rdata);
            emit               = 1'b1;
            emit_item.status   = ST_FIRED;
            emit_item.slot_out = 4'(idx_r);
            emit_item.last     = 1'b0;
          end
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
      end
      S_FIN: begin
        idx_nxt = '0;
        if (out_ok) begin
          emit             = 1'b1;
          emit_item.status = ST_DONE;
          emit_item.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        idx_nxt   = '0;
        state_nxt = S_IDLE;
      end
    endcase

    out_vld_nxt = emit ? 1'b1 : (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      in_use_r   <= '0;
      out_vld_r  <= 1'b0;
      out_item_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      in_use_r  <= in_use_nxt;
      out_vld_r <= out_vld_nxt;
      if (emit) begin
        out_item_r <= emit_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r   <= in_data.kind;
      slot_r   <= in_data.slot;
      period_r <= PERIOD_BITS'(in_data.period);
      now_r    <= TIME_BITS'(in_data.now);
    end
  end

endmodule
